// ----- hdl/fdep_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// FAT directory entry parser package
// Shared types and constants for the 8.3 directory entry parser.
// ----------------------------------------------------------------------------
package fdep_pkg;

    localparam int NAME_LEN = 11;

    localparam logic [7:0] BYTE_NULL    = 8'h00;
    localparam logic [7:0] BYTE_SPACE   = 8'h20;
    localparam logic [7:0] BYTE_DELETED = 8'hE5;
    localparam logic [7:0] BYTE_ESCAPE  = 8'h05;

    localparam logic [4:0] POS_ATTR     = 5'd11;
    localparam logic [4:0] POS_CLUS_HI0 = 5'd20;
    localparam logic [4:0] POS_CLUS_HI1 = 5'd21;
    localparam logic [4:0] POS_CLUS_LO0 = 5'd26;
    localparam logic [4:0] POS_CLUS_LO1 = 5'd27;
    localparam logic [4:0] POS_SIZE0    = 5'd28;
    localparam logic [4:0] POS_SIZE1    = 5'd29;
    localparam logic [4:0] POS_SIZE2    = 5'd30;
    localparam logic [4:0] POS_LAST     = 5'd31;

    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_END   = 1'b1;

    typedef logic [NAME_LEN-1:0][7:0] name_bytes_t;

    typedef struct packed {
        logic [31:0] start_cluster;
        logic [31:0] file_size;
        logic [5:0]  attributes;
        logic [63:0] name_low;
        logic [23:0] name_high;
        logic [3:0]  name_length;
    } entry_t;

    typedef struct packed {
        logic   has_entry;
        logic   has_end;
        entry_t entry;
    } event_t;

    typedef struct packed {
        logic   result_kind;
        entry_t entry;
        logic   last_of_run;
    } result_t;

endpackage
`default_nettype wire

// ----- hdl/fdep_entry_conv.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Entry converter
// Maps the attribute byte and converts the raw 8.3 name or volume label.
// ----------------------------------------------------------------------------
module fdep_entry_conv
(
    input  wire fdep_pkg::name_bytes_t name_bytes,
    input  wire logic [7:0]            attribute_byte,
    input  wire logic [31:0]           cluster_word,
    input  wire logic [31:0]           size_word,
    output fdep_pkg::entry_t           entry
);

    fdep_pkg::name_bytes_t chars;
    logic [3:0]            count;

    always_comb
    begin : p_name
        logic       run;
        logic       ok;
        logic       lead;
        logic [3:0] base_cnt;
        logic [3:0] ext_cnt;
        logic [3:0] vol_cnt;
        logic [3:0] idx;
        lead     = (name_bytes[0] == fdep_pkg::BYTE_ESCAPE);
        base_cnt = 4'd0;
        ext_cnt  = 4'd0;
        vol_cnt  = 4'd0;
        idx      = 4'd0;
        run      = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            ok  = (name_bytes[i] != fdep_pkg::BYTE_SPACE && name_bytes[i] != fdep_pkg::BYTE_NULL)
                  || (i == 0 && lead);
            run = run && ok;
            if (run)
            begin
                base_cnt = base_cnt + 4'd1;
            end
        end
        run = 1'b1;
        for (int i = 8; i < fdep_pkg::NAME_LEN; i++)
        begin
            ok  = name_bytes[i] != fdep_pkg::BYTE_SPACE && name_bytes[i] != fdep_pkg::BYTE_NULL;
            run = run && ok;
            if (run)
            begin
                ext_cnt = ext_cnt + 4'd1;
            end
        end
        run = 1'b1;
        for (int i = 0; i < fdep_pkg::NAME_LEN; i++)
        begin
            run = run && (name_bytes[i] != fdep_pkg::BYTE_NULL);
            if (run)
            begin
                vol_cnt = vol_cnt + 4'd1;
            end
        end

        chars = '0;
        if (attribute_byte[3])
        begin
            count = vol_cnt;
            for (int k = 0; k < fdep_pkg::NAME_LEN; k++)
            begin
                if (4'(k) < vol_cnt)
                begin
                    chars[k] = name_bytes[k];
                end
            end
        end
        else
        begin
            count = base_cnt + ext_cnt;
            for (int k = 0; k < fdep_pkg::NAME_LEN; k++)
            begin
                idx = 4'(k) - base_cnt;
                if (k < 8 && 4'(k) < base_cnt)
                begin
                    chars[k] = (k == 0 && lead) ? fdep_pkg::BYTE_DELETED : name_bytes[k];
                end
                else if (idx < ext_cnt)
                begin
                    chars[k] = name_bytes[4'd8 + {2'b00, idx[1:0]}];
                end
            end
        end
    end

    always_comb
    begin
        entry.start_cluster = cluster_word;
        entry.file_size     = size_word;
        entry.attributes    = {attribute_byte[3], attribute_byte[5], attribute_byte[2],
                               attribute_byte[1], attribute_byte[0], attribute_byte[4]};
        entry.name_low      = chars[7:0];
        entry.name_high     = chars[10:8];
        entry.name_length   = count;
    end

endmodule
`default_nettype wire

// ----- hdl/fdep_collector.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Entry collector
// Tracks the byte position, gathers entry fields and raises result events.
// ----------------------------------------------------------------------------
module fdep_collector
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  data_byte,
    input  wire logic        directory_start,
    input  wire logic        buffer_end,
    output logic             push,
    output fdep_pkg::event_t ev
);

    logic [4:0]            offset_reg;
    logic [4:0]            offset_next;
    logic                  ended_reg;
    logic                  ended_next;
    fdep_pkg::name_bytes_t name_reg;
    logic [7:0]            attr_reg;
    logic [31:0]           cluster_reg;
    logic [31:0]           size_reg;

    logic [4:0]            pos;
    logic                  ended_eff;
    logic                  skip;
    logic                  first_null;
    fdep_pkg::entry_t      conv;

    assign pos       = directory_start ? 5'd0 : offset_reg;
    assign ended_eff = directory_start ? 1'b0 : ended_reg;
    assign first_null = (pos == 5'd0) && (data_byte == fdep_pkg::BYTE_NULL);
    assign skip = (name_reg[0] == fdep_pkg::BYTE_DELETED)
                  || (attr_reg[5:0] == 6'h0F)
                  || (attr_reg[4:3] == 2'b11);

    fdep_entry_conv u_conv
    (
        .name_bytes     (name_reg),
        .attribute_byte (attr_reg),
        .cluster_word   (cluster_reg),
        .size_word      ({data_byte, size_reg[23:0]}),
        .entry          (conv)
    );

    always_comb
    begin
        offset_next  = pos;
        ended_next   = ended_eff;
        ev.has_entry = 1'b0;
        ev.has_end   = 1'b0;
        ev.entry     = conv;
        if (!ended_eff)
        begin
            if (first_null)
            begin
                ended_next  = 1'b1;
                offset_next = 5'd0;
                ev.has_end  = 1'b1;
            end
            else
            begin
                ev.has_entry = (pos == fdep_pkg::POS_LAST) && !skip;
                offset_next  = pos + 5'd1;
                if (buffer_end)
                begin
                    ended_next  = 1'b1;
                    offset_next = 5'd0;
                    ev.has_end  = 1'b1;
                end
            end
        end
        push = accept && (ev.has_entry || ev.has_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= 5'd0;
            ended_reg  <= 1'b0;
        end
        else if (accept)
        begin
            offset_reg <= offset_next;
            ended_reg  <= ended_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !ended_eff && !first_null)
        begin
            if (pos < 5'(fdep_pkg::NAME_LEN))
            begin
                name_reg[pos[3:0]] <= data_byte;
            end
            case (pos)
                fdep_pkg::POS_ATTR:     attr_reg            <= data_byte;
                fdep_pkg::POS_CLUS_HI0: cluster_reg[23:16]  <= data_byte;
                fdep_pkg::POS_CLUS_HI1: cluster_reg[31:24]  <= data_byte;
                fdep_pkg::POS_CLUS_LO0: cluster_reg[7:0]    <= data_byte;
                fdep_pkg::POS_CLUS_LO1: cluster_reg[15:8]   <= data_byte;
                fdep_pkg::POS_SIZE0:    size_reg[7:0]       <= data_byte;
                fdep_pkg::POS_SIZE1:    size_reg[15:8]      <= data_byte;
                fdep_pkg::POS_SIZE2:    size_reg[23:16]     <= data_byte;
                fdep_pkg::POS_LAST:     size_reg[31:24]     <= data_byte;
                default:                ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- hdl/fdep_result_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Result stage
// Holds one event and unrolls it into one or two results in the output register.
// ----------------------------------------------------------------------------
module fdep_result_stage
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire fdep_pkg::event_t  ev,
    output logic                   ev_ready,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output fdep_pkg::result_t      result
);

    logic              ev_valid_reg;
    logic              ev_valid_next;
    logic              ev_entry_reg;
    logic              ev_entry_next;
    logic              ev_end_reg;
    fdep_pkg::entry_t  ev_data_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    fdep_pkg::result_t result_reg;
    fdep_pkg::result_t result_next;
    logic              load;
    logic              done;

    assign load     = ev_valid_reg && (!out_valid_reg || out_ready);
    assign done     = !ev_entry_reg || !ev_end_reg;
    assign ev_ready = !ev_valid_reg || (load && done);

    always_comb
    begin
        result_next   = result_reg;
        ev_entry_next = ev_entry_reg;
        ev_valid_next = ev_valid_reg;
        if (load)
        begin
            if (ev_entry_reg)
            begin
                result_next.result_kind = fdep_pkg::KIND_ENTRY;
                result_next.entry       = ev_data_reg;
                result_next.last_of_run = !ev_end_reg;
                ev_entry_next           = 1'b0;
            end
            else
            begin
                result_next.result_kind = fdep_pkg::KIND_END;
                result_next.entry       = '0;
                result_next.last_of_run = 1'b1;
            end
            if (done)
            begin
                ev_valid_next = 1'b0;
            end
        end
        if (push)
        begin
            ev_valid_next = 1'b1;
            ev_entry_next = ev.has_entry;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg  <= 1'b0;
            ev_entry_reg  <= 1'b0;
            ev_end_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ev_valid_reg  <= ev_valid_next;
            ev_entry_reg  <= ev_entry_next;
            out_valid_reg <= out_valid_next;
            if (push)
            begin
                ev_end_reg <= ev.has_end;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ev_data_reg <= ev.entry;
        end
        result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule
`default_nettype wire

// ----- hdl/fat_directory_entry_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// FAT directory entry parser
// Path: each result is held in the event register and then moved into the output register.
// Throughput: one byte per cycle while the output takes results; a byte that yields an entry and an end
// result holds the input while the event register unrolls.
// Reset: asynchronous, active low; clears position, end flag and valid flags.
// ----------------------------------------------------------------------------
module fat_directory_entry_parser
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        directory_start,
    input  wire logic        buffer_end,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             result_kind,
    output logic [31:0]      start_cluster,
    output logic [31:0]      file_size,
    output logic [5:0]       attributes,
    output logic [63:0]      name_low,
    output logic [23:0]      name_high,
    output logic [3:0]       name_length,
    output logic             last_of_run
);

    logic              accept;
    logic              push;
    logic              ev_ready;
    fdep_pkg::event_t  ev;
    fdep_pkg::result_t result;

    assign accept   = in_valid && ev_ready;
    assign in_ready = ev_ready;

    fdep_collector u_collector
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .data_byte       (data_byte),
        .directory_start (directory_start),
        .buffer_end      (buffer_end),
        .push            (push),
        .ev              (ev)
    );

    fdep_result_stage u_result
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .ev        (ev),
        .ev_ready  (ev_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .result    (result)
    );

    assign result_kind   = result.result_kind;
    assign start_cluster = result.entry.start_cluster;
    assign file_size     = result.entry.file_size;
    assign attributes    = result.entry.attributes;
    assign name_low      = result.entry.name_low;
    assign name_high     = result.entry.name_high;
    assign name_length   = result.entry.name_length;
    assign last_of_run   = result.last_of_run;

`ifndef ASSERT_OFF
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == fdep_pkg::KIND_END) |-> last_of_run && (name_length == 4'd0))
        else $error("end transaction without last flag or with a name");

    a_name_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> name_length <= 4'(fdep_pkg::NAME_LEN))
        else $error("name length out of range");

    a_no_dir_volume: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == fdep_pkg::KIND_ENTRY) |-> !(attributes[0] && attributes[5]))
        else $error("directory volume entry not dropped");
`endif

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT directory entry parser testbench
// Streams directory bytes into the parser with random gaps and output stalls,
// predicts every entry and end-of-directory result, and checks each result
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------

localparam logic [7:0] ATTR_RO      = 8'h01;
localparam logic [7:0] ATTR_HIDDEN  = 8'h02;
localparam logic [7:0] ATTR_SYSTEM  = 8'h04;
localparam logic [7:0] ATTR_VOLUME  = 8'h08;
localparam logic [7:0] ATTR_DIR     = 8'h10;
localparam logic [7:0] ATTR_ARCHIVE = 8'h20;
localparam logic [7:0] ATTR_LFN     = 8'h0F;
localparam logic [7:0] ATTR_SPARE   = 8'hC0;

typedef logic [31:0][7:0] entry_img_t;

class dir_result_tracker;
    fdep_pkg::result_t     pending[$];
    logic [4:0]            pos;
    bit                    done;
    fdep_pkg::name_bytes_t short_name;
    logic [7:0]            attr;
    logic [31:0]           first_clus;
    logic [31:0]           file_len;
    int                    fail_count;
    int                    entry_count;
    int                    end_count;

    function new();
        pos         = '0;
        done        = 1'b0;
        short_name  = '0;
        attr        = '0;
        first_clus  = '0;
        file_len    = '0;
        fail_count  = 0;
        entry_count = 0;
        end_count   = 0;
    endfunction

    function fdep_pkg::result_t end_marker();
        fdep_pkg::result_t r;
        r = '0;
        r.result_kind = fdep_pkg::KIND_END;
        r.last_of_run = 1'b1;
        return r;
    endfunction

    function fdep_pkg::result_t convert_entry();
        fdep_pkg::result_t     r;
        fdep_pkg::name_bytes_t chars;
        int                    n;
        int                    i;
        chars = '0;
        n = 0;
        if (attr[3])
        begin
            for (i = 0; i < fdep_pkg::NAME_LEN; i++)
            begin
                if (short_name[i] == fdep_pkg::BYTE_NULL)
                    break;
                chars[n] = short_name[i];
                n++;
            end
        end
        else
        begin
            i = 0;
            if (short_name[0] == fdep_pkg::BYTE_ESCAPE)
            begin
                chars[0] = fdep_pkg::BYTE_DELETED;
                n = 1;
                i = 1;
            end
            for (; i < 8; i++)
            begin
                if (short_name[i] == fdep_pkg::BYTE_SPACE || short_name[i] == fdep_pkg::BYTE_NULL)
                    break;
                chars[n] = short_name[i];
                n++;
            end
            for (i = 8; i < fdep_pkg::NAME_LEN; i++)
            begin
                if (short_name[i] == fdep_pkg::BYTE_SPACE || short_name[i] == fdep_pkg::BYTE_NULL)
                    break;
                chars[n] = short_name[i];
                n++;
            end
        end
        r = '0;
        r.result_kind         = fdep_pkg::KIND_ENTRY;
        r.entry.start_cluster = first_clus;
        r.entry.file_size     = file_len;
        r.entry.attributes    = {attr[3], attr[5], attr[2], attr[1], attr[0], attr[4]};
        r.entry.name_low      = chars[7:0];
        r.entry.name_high     = chars[10:8];
        r.entry.name_length   = n[3:0];
        return r;
    endfunction

    function void take_byte(logic [7:0] b, logic first, logic last);
        fdep_pkg::result_t r;
        bit                skip;
        if (first)
        begin
            pos  = '0;
            done = 1'b0;
        end
        if (done)
            return;
        if (pos == 5'd0 && b == fdep_pkg::BYTE_NULL)
        begin
            done = 1'b1;
            pending.push_back(end_marker());
            end_count++;
            return;
        end
        if (pos < fdep_pkg::POS_ATTR)
            short_name[pos[3:0]] = b;
        else if (pos == fdep_pkg::POS_ATTR)
            attr = b;
        else if (pos == fdep_pkg::POS_CLUS_HI0)
            first_clus[23:16] = b;
        else if (pos == fdep_pkg::POS_CLUS_HI1)
            first_clus[31:24] = b;
        else if (pos == fdep_pkg::POS_CLUS_LO0)
            first_clus[7:0] = b;
        else if (pos == fdep_pkg::POS_CLUS_LO1)
            first_clus[15:8] = b;
        else if (pos >= fdep_pkg::POS_SIZE0)
            file_len[8 * (pos - fdep_pkg::POS_SIZE0) +: 8] = b;
        if (pos == fdep_pkg::POS_LAST)
        begin
            skip = (short_name[0] == fdep_pkg::BYTE_DELETED) || (attr[5:0] == ATTR_LFN[5:0])
                   || (attr[4] && attr[3]);
            if (!skip)
            begin
                r = convert_entry();
                r.last_of_run = !last;
                pending.push_back(r);
                entry_count++;
            end
            pos = '0;
        end
        else
            pos = pos + 5'd1;
        if (last)
        begin
            done = 1'b1;
            pos  = '0;
            pending.push_back(end_marker());
            end_count++;
        end
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("ERROR: %s expected %h, got %h", field, want, got);
        end
    endfunction

    function void check_result(fdep_pkg::result_t got);
        fdep_pkg::result_t want;
        if (pending.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("ERROR: result of kind %0d with nothing outstanding", got.result_kind);
            return;
        end
        want = pending.pop_front();
        compare("result_kind", want.result_kind, got.result_kind);
        compare("start_cluster", want.entry.start_cluster, got.entry.start_cluster);
        compare("file_size", want.entry.file_size, got.entry.file_size);
        compare("attributes", want.entry.attributes, got.entry.attributes);
        compare("name_low", want.entry.name_low, got.entry.name_low);
        compare("name_high", want.entry.name_high, got.entry.name_high);
        compare("name_length", want.entry.name_length, got.entry.name_length);
        compare("last_of_run", want.last_of_run, got.last_of_run);
    endfunction

    function void close_out();
        if (pending.size() != 0)
        begin
            fail_count++;
            $display("ERROR: %0d results never arrived", pending.size());
        end
    endfunction
endclass

module testbench;

    localparam int ITEMS       = 1000;
    localparam int HOLD_START  = 1500;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN       = 20;
    localparam int LIMIT       = 1000000;

    typedef enum int {TERM_NULL, TERM_END_LAST, TERM_END_PARTIAL, TERM_RESTART} dir_term_e;

    logic        clk;
    logic        rst_n           = 1'b0;
    logic        in_valid        = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte       = 8'h00;
    logic        directory_start = 1'b0;
    logic        buffer_end      = 1'b0;
    logic        out_valid;
    logic        out_ready       = 1'b0;
    logic        result_kind;
    logic [31:0] start_cluster;
    logic [31:0] file_size;
    logic [5:0]  attributes;
    logic [63:0] name_low;
    logic [23:0] name_high;
    logic [3:0]  name_length;
    logic        last_of_run;

    dir_result_tracker sb;
    bit                burst;
    bit                hold_done;
    int                cycles;
    int                bytes_sent;
    int                noise_bytes;

    fat_directory_entry_parser i_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .directory_start (directory_start),
        .buffer_end      (buffer_end),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_kind     (result_kind),
        .start_cluster   (start_cluster),
        .file_size       (file_size),
        .attributes      (attributes),
        .name_low        (name_low),
        .name_high       (name_high),
        .name_length     (name_length),
        .last_of_run     (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap(bit quiet);
        int p;
        if (quiet)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic fdep_pkg::name_bytes_t name_from_str(string s);
        fdep_pkg::name_bytes_t nm;
        int                    i;
        nm = '0;
        for (i = 0; i < fdep_pkg::NAME_LEN && i < s.len(); i++)
            nm[i] = s[i];
        return nm;
    endfunction

    function automatic entry_img_t make_entry(fdep_pkg::name_bytes_t nm, logic [7:0] at,
                                              logic [31:0] clus, logic [31:0] len);
        entry_img_t img;
        int         i;
        for (i = 0; i < 32; i++)
            img[i] = 8'($urandom_range(0, 255));
        for (i = 0; i < fdep_pkg::NAME_LEN; i++)
            img[i] = nm[i];
        img[fdep_pkg::POS_ATTR]     = at;
        img[fdep_pkg::POS_CLUS_HI0] = clus[23:16];
        img[fdep_pkg::POS_CLUS_HI1] = clus[31:24];
        img[fdep_pkg::POS_CLUS_LO0] = clus[7:0];
        img[fdep_pkg::POS_CLUS_LO1] = clus[15:8];
        img[fdep_pkg::POS_SIZE0]    = len[7:0];
        img[fdep_pkg::POS_SIZE1]    = len[15:8];
        img[fdep_pkg::POS_SIZE2]    = len[23:16];
        img[fdep_pkg::POS_LAST]     = len[31:24];
        return img;
    endfunction

    function automatic entry_img_t random_entry();
        entry_img_t            img;
        fdep_pkg::name_bytes_t nm;
        logic [7:0]            at;
        logic [7:0]            pad;
        int                    kind;
        int                    blen;
        int                    elen;
        int                    i;
        kind = $urandom_range(0, 99);
        blen = $urandom_range(0, 8);
        elen = $urandom_range(0, 3);
        pad  = $urandom_range(0, 1) ? fdep_pkg::BYTE_SPACE : fdep_pkg::BYTE_NULL;
        for (i = 0; i < fdep_pkg::NAME_LEN; i++)
            nm[i] = pad;
        for (i = 0; i < blen; i++)
            nm[i] = 8'($urandom_range(8'h21, 8'h7E));
        for (i = 0; i < elen; i++)
            nm[8 + i] = 8'($urandom_range(8'h21, 8'h7E));
        if ($urandom_range(0, 4) == 0)
            nm[$urandom_range(0, fdep_pkg::NAME_LEN - 1)] = 8'($urandom_range(0, 255));
        if (nm[0] == fdep_pkg::BYTE_NULL)
            nm[0] = fdep_pkg::BYTE_SPACE;
        at = 8'($urandom_range(0, 255));
        if (kind < 45)
            at = at & ~(ATTR_DIR | ATTR_VOLUME);
        else if (kind < 57)
            at = (at & ~ATTR_VOLUME) | ATTR_DIR;
        else if (kind < 63)
            nm[0] = fdep_pkg::BYTE_DELETED;
        else if (kind < 71)
            at = (at & ATTR_SPARE) | ATTR_LFN;
        else if (kind < 76)
            at = at | ATTR_DIR | ATTR_VOLUME;
        else if (kind < 83)
            at = (at & ~ATTR_DIR) | ATTR_VOLUME;
        else if (kind < 89)
        begin
            nm[0] = fdep_pkg::BYTE_ESCAPE;
            at = at & ~(ATTR_DIR | ATTR_VOLUME);
        end
        else
        begin
            for (i = 0; i < 32; i++)
                img[i] = 8'($urandom_range(0, 255));
            return img;
        end
        img = make_entry(nm, at, $urandom, $urandom);
        return img;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        int gap;
        gap = pick_gap(burst);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        data_byte       <= b;
        directory_start <= first;
        buffer_end      <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.take_byte(b, first, last);
        bytes_sent++;
    endtask

    task automatic send_run(input entry_img_t img, input int count,
                            input bit first_start, input bit end_last);
        int i;
        for (i = 0; i < count; i++)
            send_byte(img[i], first_start && (i == 0), end_last && (i == count - 1));
    endtask

    task automatic send_noise();
        int n;
        int i;
        n = $urandom_range(0, 4);
        for (i = 0; i < n; i++)
        begin
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
            noise_bytes++;
        end
    endtask

    task automatic run_directed();
        fdep_pkg::name_bytes_t nm;
        entry_img_t            img;
        nm = name_from_str("README  TXT");
        send_run(make_entry(nm, ATTR_ARCHIVE, 32'h1234_5678, 32'd1000), 32, 1'b1, 1'b0);
        nm[0] = fdep_pkg::BYTE_DELETED;
        send_run(make_entry(nm, ATTR_ARCHIVE, 32'h0000_0001, 32'h2), 32, 1'b0, 1'b0);
        img = make_entry(name_from_str("ALONGNAMEXY"), ATTR_LFN | ATTR_SPARE, 32'h5, 32'h6);
        send_run(img, 32, 1'b0, 1'b0);
        send_run(make_entry(name_from_str("DIRVOL  BAD"), ATTR_DIR | ATTR_VOLUME, 32'h7, 32'h8),
                 32, 1'b0, 1'b0);
        send_run(make_entry(name_from_str("MY DISK"), ATTR_VOLUME | ATTR_ARCHIVE, 32'h0, 32'h0),
                 32, 1'b0, 1'b0);
        nm = name_from_str("XSCAPE  DAT");
        nm[0] = fdep_pkg::BYTE_ESCAPE;
        send_run(make_entry(nm, ATTR_DIR | ATTR_HIDDEN, 32'h0002_0003, 32'd512), 32, 1'b0, 1'b0);
        nm = '1;
        send_run(make_entry(nm, ATTR_SPARE | ATTR_DIR | ATTR_ARCHIVE | ATTR_RO | ATTR_HIDDEN
                            | ATTR_SYSTEM, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 32, 1'b0, 1'b0);
        send_run(make_entry(name_from_str("A"), ATTR_RO, 32'h0, 32'h0), 32, 1'b0, 1'b0);
        send_run(make_entry(name_from_str("ABCDEFGHIJK"), ATTR_SYSTEM, 32'h0001_0000,
                            32'h8000_0000), 32, 1'b0, 1'b0);
        send_run(make_entry(name_from_str("AB CD   E F"), ATTR_ARCHIVE, 32'h0000_FFFF,
                            32'h0000_0001), 32, 1'b0, 1'b0);
        send_run(make_entry(name_from_str("        TXT"), ATTR_ARCHIVE, 32'hFFFF_0000,
                            32'h7FFF_FFFF), 32, 1'b0, 1'b0);
        send_byte(fdep_pkg::BYTE_NULL, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b1);
        send_byte(8'h55, 1'b0, 1'b0);
        noise_bytes += 2;
        send_run(make_entry(name_from_str("LAST    ONE"), ATTR_ARCHIVE, 32'h9, 32'hA),
                 32, 1'b1, 1'b1);
        send_run(make_entry(name_from_str("CUT     OFF"), ATTR_ARCHIVE, 32'hB, 32'hC),
                 11, 1'b1, 1'b1);
        send_byte(fdep_pkg::BYTE_NULL, 1'b1, 1'b1);
        send_run(img, 32, 1'b1, 1'b1);
        send_run(make_entry(name_from_str("BROKEN  ENT"), ATTR_ARCHIVE, 32'hD, 32'hE),
                 15, 1'b1, 1'b0);
        send_run(make_entry(name_from_str("FRESH   ENT"), ATTR_DIR, 32'hF, 32'h10),
                 32, 1'b1, 1'b0);
        send_byte(fdep_pkg::BYTE_NULL, 1'b0, 1'b0);
    endtask

    task automatic run_random();
        dir_term_e term;
        int        n;
        int        k;
        int        p;
        int        cnt;
        while (bytes_sent < ITEMS)
        begin
            burst = ($urandom_range(0, 3) == 0);
            n = $urandom_range(0, 6);
            p = $urandom_range(0, 99);
            term = (p < 40) ? TERM_NULL : (p < 70) ? TERM_END_LAST :
                   (p < 90) ? TERM_END_PARTIAL : TERM_RESTART;
            for (k = 0; k < n; k++)
                send_run(random_entry(), 32, k == 0, term == TERM_END_LAST && k == n - 1);
            case (term)
                TERM_NULL:
                    send_byte(fdep_pkg::BYTE_NULL, n == 0, 1'b0);
                TERM_END_LAST:
                    if (n == 0)
                        send_byte(fdep_pkg::BYTE_NULL, 1'b1, 1'b1);
                default:
                begin
                    cnt = $urandom_range(1, 31);
                    send_run(random_entry(), cnt, n == 0, term == TERM_END_PARTIAL);
                end
            endcase
            if (term != TERM_RESTART)
                send_noise();
        end
        burst = 1'b0;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        fdep_pkg::result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.result_kind         = result_kind;
            got.entry.start_cluster = start_cluster;
            got.entry.file_size     = file_size;
            got.entry.attributes    = attributes;
            got.entry.name_low      = name_low;
            got.entry.name_high     = name_high;
            got.entry.name_length   = name_length;
            got.last_of_run         = last_of_run;
            sb.check_result(got);
        end
    end

    // hold off once for a long stretch so that the parser fills and stalls its input
    initial
    begin
        int run;
        int stall;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 40);
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
            if (!hold_done && cycles >= HOLD_START)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                stall = pick_gap(1'b0);
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        sb          = new();
        burst       = 1'b0;
        hold_done   = 1'b0;
        bytes_sent  = 0;
        noise_bytes = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        sb.close_out();
        $display("Run covered %0d directory bytes (%0d ignored after an end),",
                 bytes_sent - noise_bytes, noise_bytes);
        $display("%0d entries, %0d ends; receiver hold-off of %0d cycles %0s; %0d cycles",
                 sb.entry_count, sb.end_count, HOLD_CYCLES,
                 hold_done ? "applied" : "not reached", cycles);
        if (sb.fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- fat_directory_entry_parser.f -----
hdl/fdep_pkg.sv
hdl/fdep_entry_conv.sv
hdl/fdep_collector.sv
hdl/fdep_result_stage.sv
hdl/fat_directory_entry_parser.sv
sim/testbench.sv
